### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BOLE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BOLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/bole_pkg.sv
// Shared types and codes of the bounded ordered list engine.
`timescale 1ns / 1ps
package bole_pkg;

  typedef enum logic [3:0] {
    OP_INS_HEAD   = 4'd0,
    OP_INS_TAIL   = 4'd1,
    OP_INS_AFTER  = 4'd2,
    OP_INS_BEFORE = 4'd3,
    OP_INS_POS    = 4'd4,
    OP_DEL_HEAD   = 4'd5,
    OP_DEL_TAIL   = 4'd6,
    OP_DEL_VALUE  = 4'd7,
    OP_DEL_POS    = 4'd8,
    OP_CLEAR      = 4'd9,
    OP_READ       = 4'd10
  } op_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_NOKEY  = 3'd2,
    ST_BADPOS = 3'd3,
    ST_RANGE  = 3'd4,
    ST_FULL   = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    P_HOLD  = 3'd0,
    P_ZERO  = 3'd1,
    P_COUNT = 3'd2,
    P_LAST  = 3'd3,
    P_POS   = 3'd4,
    P_INC   = 3'd5,
    P_DEC   = 3'd6,
    P_FOUND = 3'd7
  } ptr_op_e;

  typedef enum logic [2:0] {
    L_HOLD  = 3'd0,
    L_ZERO  = 3'd1,
    L_COUNT = 3'd2,
    L_POS   = 3'd3,
    L_FOUND = 3'd4
  } lo_op_e;

  typedef enum logic [1:0] {
    R_NONE = 2'd0,
    R_PTR  = 2'd1,
    R_PREV = 2'd2,
    R_NEXT = 2'd3
  } rd_sel_e;

  typedef enum logic [1:0] {
    C_HOLD = 2'd0,
    C_INC  = 2'd1,
    C_DEC  = 2'd2,
    C_CLR  = 2'd3
  } cnt_op_e;

  typedef struct packed {
    logic    cap;
    ptr_op_e ptr_op;
    lo_op_e  lo_op;
    rd_sel_e rd_sel;
    logic    wr_val;
    cnt_op_e cnt_op;
    logic    out_res;
    logic    out_item;
    status_e status;
  } bole_cmd_t;

  typedef struct packed {
    op_e  op;
    logic empty;
    logic full;
    logic pos_bad;
    logic ins_range;
    logic del_range;
    logic ptr_gt_lo;
    logic next_lt_cnt;
    logic ptr_lt_cnt;
    logic pend;
    logic rv;
    logic match;
    logic sidx_last;
    logic ptr_last;
    logic out_free;
  } bole_sts_t;

endpackage

### rtl/bounded_ordered_list_engine.sv
// Top level of the bounded ordered list engine.
`timescale 1ns / 1ps
// Ordered list of up to CAPACITY signed 32-bit entries, head first.
// Request channel: in_valid_i / in_stall_o with op_i, value_i, key_i and
//   position_i; a request is taken when in_valid_i is high and in_stall_o low.
// Result channel: out_valid_o / out_stall_i with status_o, item_value_o,
//   last_o and length_o; last_o marks the final result of a request.
// Every request gives one result, except read out of a non-empty list,
//   which gives one result per entry from head to tail.
// One request at a time: head, tail and position requests shift entries
//   one per cycle through the single write port of the RAM.
//   Key requests search up to the first match and shift from there on, so
//   together they walk the list once.
//   Read out issues a RAM read for each entry, then loads its result.
// Reset empties the list at once; entry storage is not cleared.
// The result register decouples the sides: a new request is taken while the
//   last result still waits; a stalled result holds and the engine waits
//   before loading the next one.
module bounded_ordered_list_engine import bole_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [3:0]         op_i,
  input  logic signed [31:0] value_i,
  input  logic signed [31:0] key_i,
  input  logic signed [31:0] position_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic signed [31:0] item_value_o,
  output logic               last_o,
  output logic [6:0]         length_o
);

  bole_cmd_t cmd;
  bole_sts_t sts;

  // sequence each request: decode, search, shift, report
  bole_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // hold entries, count and the result register
  bole_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op_i),
    .value_i     (value_i),
    .key_i       (key_i),
    .position_i  (position_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .status_o    (status_o),
    .item_value_o(item_value_o),
    .last_o      (last_o),
    .length_o    (length_o)
  );

endmodule

### rtl/bole_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bole_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### rtl/bole_dp.sv
// Datapath: entry RAM, count, pointers, shift pipeline and result register.
`timescale 1ns / 1ps
module bole_dp import bole_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [3:0]         op_i,
  input  logic signed [31:0] value_i,
  input  logic signed [31:0] key_i,
  input  logic signed [31:0] position_i,
  input  bole_cmd_t          cmd_i,
  output bole_sts_t          sts_o,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic [2:0]         status_o,
  output logic signed [31:0] item_value_o,
  output logic               last_o,
  output logic [6:0]         length_o
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [3:0]    op_q;
  logic [31:0]   value_q, key_q, pos_q;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] ptr_q, ptr_d, lo_q, lo_d, sidx_q, sidx_d;
  logic [CW-1:0] ptr_inc, ptr_dec, pos_m1;
  logic [AW-1:0] waddr_q, waddr_d;
  logic          pend_q, pend_d, rv_q, rv_d;
  logic          ovalid_q, ovalid_d;
  logic [2:0]    ostat_q, ostat_d;
  logic [31:0]   oitem_q, oitem_d;
  logic          olast_q, olast_d;
  logic [6:0]    olen_q, olen_d;
  logic [31:0]   cnt32;
  logic          re;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata, rdata;

  assign ptr_inc = ptr_q + CW'(1);
  assign ptr_dec = ptr_q - CW'(1);
  assign pos_m1  = CW'(pos_q - 32'd1);
  assign cnt32   = 32'(count_q);

  // status toward the controller
  always_comb begin
    sts_o.op          = op_e'(op_q);
    sts_o.empty       = (count_q == '0);
    sts_o.full        = (count_q >= CW'(CAPACITY));
    sts_o.pos_bad     = pos_q[31] || (pos_q == 32'd0);
    sts_o.ins_range   = ({1'b0, pos_q} > (33'(count_q) + 33'd1));
    sts_o.del_range   = ({1'b0, pos_q} > 33'(count_q));
    sts_o.ptr_gt_lo   = (ptr_q > lo_q);
    sts_o.next_lt_cnt = (ptr_inc < count_q);
    sts_o.ptr_lt_cnt  = (ptr_q < count_q);
    sts_o.pend        = pend_q;
    sts_o.rv          = rv_q;
    sts_o.match       = (rdata == key_q);
    sts_o.sidx_last   = ((sidx_q + CW'(1)) == count_q);
    sts_o.ptr_last    = (ptr_inc == count_q);
    sts_o.out_free    = !ovalid_q || !out_stall_i;
  end

  // RAM port control: a pending shift write always drains first
  always_comb begin
    re    = (cmd_i.rd_sel != R_NONE);
    raddr = ptr_q[AW-1:0];
    case (cmd_i.rd_sel)
      R_PREV:  raddr = ptr_dec[AW-1:0];
      R_NEXT:  raddr = ptr_inc[AW-1:0];
      default: raddr = ptr_q[AW-1:0];
    endcase
    we    = pend_q || cmd_i.wr_val;
    waddr = pend_q ? waddr_q : lo_q[AW-1:0];
    wdata = pend_q ? rdata : value_q;
    pend_d  = (cmd_i.rd_sel == R_PREV) || (cmd_i.rd_sel == R_NEXT);
    waddr_d = ptr_q[AW-1:0];
    rv_d    = (cmd_i.rd_sel == R_PTR);
    sidx_d  = ptr_q;
  end

  always_comb begin
    ptr_d = ptr_q;
    case (cmd_i.ptr_op)
      P_ZERO:  ptr_d = '0;
      P_COUNT: ptr_d = count_q;
      P_LAST:  ptr_d = count_q - CW'(1);
      P_POS:   ptr_d = pos_m1;
      P_INC:   ptr_d = ptr_inc;
      P_DEC:   ptr_d = ptr_dec;
      P_FOUND: ptr_d = sidx_q;
      default: ptr_d = ptr_q;
    endcase
    lo_d = lo_q;
    case (cmd_i.lo_op)
      L_ZERO:  lo_d = '0;
      L_COUNT: lo_d = count_q;
      L_POS:   lo_d = pos_m1;
      L_FOUND: lo_d = sidx_q + ((op_q == OP_INS_AFTER) ? CW'(1) : CW'(0));
      default: lo_d = lo_q;
    endcase
    count_d = count_q;
    case (cmd_i.cnt_op)
      C_INC:   count_d = count_q + CW'(1);
      C_DEC:   count_d = count_q - CW'(1);
      C_CLR:   count_d = '0;
      default: count_d = count_q;
    endcase
  end

  // result register
  always_comb begin
    ovalid_d = ovalid_q;
    ostat_d  = ostat_q;
    oitem_d  = oitem_q;
    olast_d  = olast_q;
    olen_d   = olen_q;
    if (cmd_i.out_res) begin
      ovalid_d = 1'b1;
      ostat_d  = cmd_i.status;
      oitem_d  = '0;
      olast_d  = 1'b1;
      olen_d   = cnt32[6:0];
    end else if (cmd_i.out_item) begin
      ovalid_d = 1'b1;
      ostat_d  = ST_OK;
      oitem_d  = rdata;
      olast_d  = sts_o.ptr_last;
      olen_d   = cnt32[6:0];
    end else if (ovalid_q && !out_stall_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      pend_q   <= 1'b0;
      rv_q     <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      pend_q   <= pend_d;
      rv_q     <= rv_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      op_q    <= op_i;
      value_q <= value_i;
      key_q   <= key_i;
      pos_q   <= position_i;
    end
    ptr_q   <= ptr_d;
    lo_q    <= lo_d;
    sidx_q  <= sidx_d;
    waddr_q <= waddr_d;
    ostat_q <= ostat_d;
    oitem_q <= oitem_d;
    olast_q <= olast_d;
    olen_q  <= olen_d;
  end

  bole_ram #(
    .WIDTH(32),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign out_valid_o  = ovalid_q;
  assign status_o     = ostat_q;
  assign item_value_o = oitem_q;
  assign last_o       = olast_q;
  assign length_o     = olen_q;

endmodule

### rtl/bole_ctrl.sv
// Controller: operation sequencer for the list engine.
`timescale 1ns / 1ps
module bole_ctrl import bole_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  bole_sts_t sts_i,
  output bole_cmd_t cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_DECODE   = 8'b0000_0010,
    S_SEARCH   = 8'b0000_0100,
    S_INS      = 8'b0000_1000,
    S_DEL      = 8'b0001_0000,
    S_RES      = 8'b0010_0000,
    S_RD_ISSUE = 8'b0100_0000,
    S_RD_LOAD  = 8'b1000_0000
  } state_e;

  state_e  state_q, state_d;
  status_e st_q, st_d;

  always_comb begin
    state_d         = state_q;
    st_d            = st_q;
    cmd_o.cap       = 1'b0;
    cmd_o.ptr_op    = P_HOLD;
    cmd_o.lo_op     = L_HOLD;
    cmd_o.rd_sel    = R_NONE;
    cmd_o.wr_val    = 1'b0;
    cmd_o.cnt_op    = C_HOLD;
    cmd_o.out_res   = 1'b0;
    cmd_o.out_item  = 1'b0;
    cmd_o.status    = st_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_RES;
        st_d    = ST_OK;
        case (sts_i.op)
          OP_INS_HEAD, OP_INS_TAIL: begin
            if (sts_i.full) begin
              st_d = ST_FULL;
            end else begin
              cmd_o.ptr_op = P_COUNT;
              cmd_o.lo_op  = (sts_i.op == OP_INS_HEAD) ? L_ZERO : L_COUNT;
              state_d      = S_INS;
            end
          end
          OP_INS_AFTER, OP_INS_BEFORE, OP_DEL_VALUE: begin
            if (sts_i.empty) begin
              st_d = ST_EMPTY;
            end else if (sts_i.full && (sts_i.op != OP_DEL_VALUE)) begin
              st_d = ST_FULL;
            end else begin
              cmd_o.ptr_op = P_ZERO;
              state_d      = S_SEARCH;
            end
          end
          OP_INS_POS: begin
            if (sts_i.pos_bad) begin
              st_d = ST_BADPOS;
            end else if (sts_i.ins_range) begin
              st_d = ST_RANGE;
            end else if (sts_i.full) begin
              st_d = ST_FULL;
            end else begin
              cmd_o.ptr_op = P_COUNT;
              cmd_o.lo_op  = L_POS;
              state_d      = S_INS;
            end
          end
          OP_DEL_HEAD, OP_DEL_TAIL: begin
            if (sts_i.empty) begin
              st_d = ST_EMPTY;
            end else begin
              cmd_o.ptr_op = (sts_i.op == OP_DEL_HEAD) ? P_ZERO : P_LAST;
              state_d      = S_DEL;
            end
          end
          OP_DEL_POS: begin
            if (sts_i.empty) begin
              st_d = ST_EMPTY;
            end else if (sts_i.pos_bad) begin
              st_d = ST_BADPOS;
            end else if (sts_i.del_range) begin
              st_d = ST_RANGE;
            end else begin
              cmd_o.ptr_op = P_POS;
              state_d      = S_DEL;
            end
          end
          OP_CLEAR: begin
            if (sts_i.empty) begin
              st_d = ST_EMPTY;
            end else begin
              cmd_o.cnt_op = C_CLR;
            end
          end
          OP_READ: begin
            if (sts_i.empty) begin
              st_d = ST_EMPTY;
            end else begin
              cmd_o.ptr_op = P_ZERO;
              state_d      = S_RD_ISSUE;
            end
          end
          default: ;
        endcase
      end
      S_SEARCH: begin
        if (sts_i.rv && sts_i.match) begin
          if (sts_i.op == OP_DEL_VALUE) begin
            cmd_o.ptr_op = P_FOUND;
            state_d      = S_DEL;
          end else begin
            cmd_o.ptr_op = P_COUNT;
            cmd_o.lo_op  = L_FOUND;
            state_d      = S_INS;
          end
        end else if (sts_i.rv && sts_i.sidx_last) begin
          st_d    = ST_NOKEY;
          state_d = S_RES;
        end else if (sts_i.ptr_lt_cnt) begin
          cmd_o.rd_sel = R_PTR;
          cmd_o.ptr_op = P_INC;
        end
      end
      S_INS: begin
        if (sts_i.ptr_gt_lo) begin
          cmd_o.rd_sel = R_PREV;
          cmd_o.ptr_op = P_DEC;
        end else if (!sts_i.pend) begin
          cmd_o.wr_val = 1'b1;
          cmd_o.cnt_op = C_INC;
          state_d      = S_RES;
        end
      end
      S_DEL: begin
        if (sts_i.next_lt_cnt) begin
          cmd_o.rd_sel = R_NEXT;
          cmd_o.ptr_op = P_INC;
        end else if (!sts_i.pend) begin
          cmd_o.cnt_op = C_DEC;
          state_d      = S_RES;
        end
      end
      S_RES: begin
        if (sts_i.out_free) begin
          cmd_o.out_res = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_RD_ISSUE: begin
        if (sts_i.out_free) begin
          cmd_o.rd_sel = R_PTR;
          state_d      = S_RD_LOAD;
        end
      end
      S_RD_LOAD: begin
        cmd_o.out_item = 1'b1;
        cmd_o.ptr_op   = P_INC;
        state_d        = sts_i.ptr_last ? S_IDLE : S_RD_ISSUE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= ST_OK;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

### rtl/bole_checker.sv
// Port-level checker for the list engine, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bole_checker import bole_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [2:0]         status_o,
  input logic signed [31:0] item_value_o,
  input logic               last_o
);

  // a failed or plain request ends with its single result
  `BOLE_ASSERT_IMP(a_err_last, out_valid_o && (status_o != ST_OK), last_o, "error result not last")
  // only read out carries entry data, always with status ok
  `BOLE_ASSERT_IMP(a_item_ok, out_valid_o && (item_value_o != 0), status_o == ST_OK, "item with bad status")
  // the engine works on one request at a time
  `BOLE_ASSERT_NEXT(a_busy, in_valid_i && !in_stall_o, in_stall_o, "took a request back to back")
  // a stalled result holds
  `BOLE_ASSERT_NEXT(a_hold, out_valid_o && out_stall_i, out_valid_o && $stable(item_value_o) && $stable(status_o) && $stable(last_o), "stalled result moved")

endmodule

bind bounded_ordered_list_engine bole_checker u_bole_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .status_o    (status_o),
  .item_value_o(item_value_o),
  .last_o      (last_o)
);

### tb/tb_top.sv
// Self-checking testbench of the bounded ordered list engine.
`timescale 1ns / 1ps
module tb_top;
  import bole_pkg::*;

  localparam int CAP = 64;
  localparam int QUIET_LIMIT = 20000;

  typedef struct {
    logic [3:0]  op;
    logic [31:0] value;
    logic [31:0] key;
    logic [31:0] position;
  } request_t;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] item_value;
    logic        last;
    logic [6:0]  length;
  } result_t;

  // Directed row: a request plus an optional hand-typed first result.
  typedef struct {
    request_t   req;
    logic       typed;
    status_e    status;
    logic [6:0] length;
  } row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [3:0]         op_i = '0;
  logic signed [31:0] value_i = '0;
  logic signed [31:0] key_i = '0;
  logic signed [31:0] position_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [2:0]         status_o;
  logic signed [31:0] item_value_o;
  logic               last_o;
  logic [6:0]         length_o;

  // Shadow copy of the list.
  logic [31:0] list_mem [CAP];
  int          list_len;
  result_t     pending_results [$];
  int          mismatches = 0;
  int          quiet_cycles = 0;
  bit          long_hold = 1'b0;

  bounded_ordered_list_engine #(.CAPACITY(CAP)) u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int find_first(logic [31:0] k);
    for (int i = 0; i < list_len; i++) if (list_mem[i] == k) return i;
    return -1;
  endfunction

  function automatic void list_insert(int idx, logic [31:0] v);
    for (int i = list_len; i > idx; i--) list_mem[i] = list_mem[i-1];
    list_mem[idx] = v;
    list_len++;
  endfunction

  function automatic void list_remove(int idx);
    for (int i = idx; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
    list_len--;
  endfunction

  // Apply one request to the shadow list and queue what the engine must answer.
  function automatic void predict_list_op(request_t r);
    status_e     st;
    int          idx;
    logic        pbad;
    logic [32:0] praw;
    result_t     res;
    st = ST_OK;
    pbad = r.position[31] || (r.position == 0);
    praw = {1'b0, r.position};
    case (r.op)
      OP_INS_HEAD, OP_INS_TAIL: begin
        if (list_len >= CAP) st = ST_FULL;
        else list_insert((r.op == OP_INS_HEAD) ? 0 : list_len, r.value);
      end
      OP_INS_AFTER, OP_INS_BEFORE: begin
        if (list_len == 0) st = ST_EMPTY;
        else if (list_len >= CAP) st = ST_FULL;
        else begin
          idx = find_first(r.key);
          if (idx < 0) st = ST_NOKEY;
          else list_insert((r.op == OP_INS_AFTER) ? idx + 1 : idx, r.value);
        end
      end
      OP_INS_POS: begin
        if (pbad) st = ST_BADPOS;
        else if (praw > list_len + 1) st = ST_RANGE;
        else if (list_len >= CAP) st = ST_FULL;
        else list_insert(int'(praw) - 1, r.value);
      end
      OP_DEL_HEAD, OP_DEL_TAIL: begin
        if (list_len == 0) st = ST_EMPTY;
        else list_remove((r.op == OP_DEL_HEAD) ? 0 : list_len - 1);
      end
      OP_DEL_VALUE: begin
        if (list_len == 0) st = ST_EMPTY;
        else begin
          idx = find_first(r.key);
          if (idx < 0) st = ST_NOKEY;
          else list_remove(idx);
        end
      end
      OP_DEL_POS: begin
        if (list_len == 0) st = ST_EMPTY;
        else if (pbad) st = ST_BADPOS;
        else if (praw > list_len) st = ST_RANGE;
        else list_remove(int'(praw) - 1);
      end
      OP_CLEAR: begin
        if (list_len == 0) st = ST_EMPTY;
        else list_len = 0;
      end
      OP_READ: begin
        if (list_len == 0) st = ST_EMPTY;
        else begin
          // Stream every entry from head, mark the tail.
          for (int i = 0; i < list_len; i++) begin
            res.status = ST_OK;
            res.item_value = list_mem[i];
            res.last = (i == list_len - 1);
            res.length = list_len[6:0];
            pending_results.push_back(res);
          end
          return;
        end
      end
      default: ;
    endcase
    res.status = st;
    res.item_value = '0;
    res.last = 1'b1;
    res.length = list_len[6:0];
    pending_results.push_back(res);
  endfunction

  function automatic void note_mismatch(string what, result_t exp_r);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: exp st=%0d val=%h last=%0d len=%0d got st=%0d val=%h last=%0d len=%0d",
               what, exp_r.status, exp_r.item_value, exp_r.last, exp_r.length,
               status_o, item_value_o, last_o, length_o);
  endfunction

  // Idle a random number of cycles, present one request, hold it until
  // taken, then feed the predictor.
  task automatic send_request(request_t r);
    int idle;
    idle = $urandom_range(0, 4);
    if (idle > 0) begin
      in_valid_i <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= r.op;
    value_i    <= r.value;
    key_i      <= r.key;
    position_i <= r.position;
    do @(posedge clk_i); while (in_stall_o);
    predict_list_op(r);
  endtask

  // Drop the request and wait until every expected result has come.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Bias keys and positions toward entries that are actually present.
  function automatic request_t rand_request();
    request_t r;
    int       pick;
    r.op = $urandom_range(0, 15);
    if ($urandom_range(0, 9) == 0) r.op = $urandom_range(11, 15);
    else r.op = $urandom_range(0, 10);
    r.value = $urandom();
    if ($urandom_range(0, 3) == 0) r.value = $urandom_range(0, 7);
    pick = $urandom_range(0, 9);
    if (pick < 7 && list_len > 0) r.key = list_mem[$urandom_range(0, list_len - 1)];
    else if (pick < 9) r.key = $urandom_range(0, 7);
    else r.key = $urandom();
    pick = $urandom_range(0, 9);
    if (pick < 7) r.position = $urandom_range(1, list_len + 1);
    else if (pick == 7) r.position = $urandom_range(0, 1) ? 32'h0 : $urandom() | 32'h8000_0000;
    else if (pick == 8) r.position = list_len + 2 + $urandom_range(0, 3);
    else r.position = $urandom();
    return r;
  endfunction

  // Result side: stall at random before each result, and once for a
  // long stretch when asked.
  initial begin
    int hold;
    bit hold_done;
    hold_done = 1'b0;
    wait (rst_ni);
    forever begin
      if (long_hold && !hold_done) begin
        hold = 600;
        hold_done = 1'b1;
      end else begin
        hold = $urandom_range(0, 4);
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        exp_r = '{default: '0};
        note_mismatch("unexpected result", exp_r);
      end else begin
        exp_r = pending_results.pop_front();
        if (status_o !== exp_r.status || item_value_o !== exp_r.item_value ||
            last_o !== exp_r.last || length_o !== exp_r.length)
          note_mismatch("field", exp_r);
      end
    end
  end

  // Watchdog: stop when nothing moves on either channel for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    row_t     rows [$];
    row_t     rw;
    request_t r;
    int       n_sent;
    list_len = 0;

    // Directed table: typed answers where the status is obvious.
    rows = '{
      '{'{OP_READ,      32'h0, 32'h0, 32'h1}, 1'b1, ST_EMPTY,  7'd0},
      '{'{OP_DEL_HEAD,  32'h0, 32'h0, 32'h1}, 1'b1, ST_EMPTY,  7'd0},
      '{'{OP_DEL_TAIL,  32'h0, 32'h0, 32'h1}, 1'b1, ST_EMPTY,  7'd0},
      '{'{OP_DEL_VALUE, 32'h0, 32'h0, 32'h1}, 1'b1, ST_EMPTY,  7'd0},
      '{'{OP_DEL_POS,   32'h0, 32'h0, 32'h0}, 1'b1, ST_EMPTY,  7'd0},
      '{'{OP_CLEAR,     32'h0, 32'h0, 32'h0}, 1'b1, ST_EMPTY,  7'd0},
      '{'{OP_INS_AFTER, 32'h5, 32'h5, 32'h1}, 1'b1, ST_EMPTY,  7'd0},
      '{'{OP_INS_POS,   32'h1, 32'h0, 32'h0}, 1'b1, ST_BADPOS, 7'd0},
      '{'{OP_INS_POS,   32'h1, 32'h0, 32'h8000_0000}, 1'b1, ST_BADPOS, 7'd0},
      '{'{OP_INS_POS,   32'h1, 32'h0, 32'h2}, 1'b1, ST_RANGE,  7'd0},
      '{'{OP_INS_POS,   32'h7FFF_FFFF, 32'h0, 32'h1}, 1'b1, ST_OK, 7'd1},
      '{'{OP_DEL_POS,   32'h0, 32'h0, 32'h2}, 1'b1, ST_RANGE,  7'd1},
      '{'{OP_DEL_POS,   32'h0, 32'h0, 32'hFFFF_FFFF}, 1'b1, ST_BADPOS, 7'd1},
      '{'{OP_INS_HEAD,  32'h8000_0000, 32'h0, 32'h0}, 1'b1, ST_OK, 7'd2},
      '{'{OP_INS_TAIL,  32'hFFFF_FFFF, 32'h0, 32'h0}, 1'b1, ST_OK, 7'd3},
      '{'{OP_INS_AFTER, 32'h1234_5678, 32'h8000_0000, 32'h0}, 1'b0, ST_OK, 7'd0},
      '{'{OP_INS_BEFORE, 32'h0, 32'hFFFF_FFFF, 32'h0}, 1'b0, ST_OK, 7'd0},
      '{'{OP_INS_BEFORE, 32'h9, 32'h1357_9BDF, 32'h0}, 1'b1, ST_NOKEY, 7'd5},
      '{'{OP_READ,      32'h0, 32'h0, 32'h0}, 1'b0, ST_OK, 7'd0},
      '{'{4'd13,        32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, ST_OK, 7'd5},
      '{'{OP_DEL_VALUE, 32'h0, 32'h7FFF_FFFF, 32'h0}, 1'b0, ST_OK, 7'd0},
      '{'{OP_DEL_POS,   32'h0, 32'h0, 32'h2}, 1'b0, ST_OK, 7'd0},
      '{'{OP_DEL_HEAD,  32'h0, 32'h0, 32'h0}, 1'b0, ST_OK, 7'd0},
      '{'{OP_DEL_TAIL,  32'h0, 32'h0, 32'h0}, 1'b0, ST_OK, 7'd0},
      '{'{OP_CLEAR,     32'h0, 32'h0, 32'h0}, 1'b1, ST_OK, 7'd0}
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      rw = rows[i];
      send_request(rw.req);
      // Typed rows expect their own answer in place of the predicted one.
      if (rw.typed) begin
        pending_results[pending_results.size() - 1].status = rw.status;
        pending_results[pending_results.size() - 1].length = rw.length;
      end
    end

    // Fill to capacity while the result side holds off, then hit full cases.
    wait_drained();
    long_hold = 1'b1;
    r = '{OP_INS_TAIL, 32'h0, 32'h0, 32'h0};
    for (int i = 0; i < CAP; i++) begin
      r.value = $urandom();
      send_request(r);
    end
    r.op = OP_INS_HEAD;   send_request(r);
    r.op = OP_INS_AFTER;  r.key = list_mem[3]; send_request(r);
    r.op = OP_INS_POS;    r.position = 32'd65; send_request(r);
    r.op = OP_INS_POS;    r.position = 32'd66; send_request(r);
    r.op = OP_READ;       send_request(r);
    // Pause until the engine has answered everything.
    wait_drained();

    n_sent = 0;
    while (n_sent < 166) begin
      r = rand_request();
      // Keep lists short most of the time, occasionally let them grow.
      if (list_len > 20 && $urandom_range(0, 3) == 0) r.op = OP_DEL_HEAD;
      send_request(r);
      n_sent++;
    end

    wait_drained();
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

### sim.f
+incdir+rtl
rtl/bole_pkg.sv
rtl/bole_ram.sv
rtl/bole_dp.sv
rtl/bole_ctrl.sv
rtl/bounded_ordered_list_engine.sv
rtl/bole_checker.sv
tb/tb_top.sv
